// File: rtl/cbt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the tree engine.
package cbt_pkg;

  localparam int CAPACITY = 64;
  localparam int NODE_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int LEAF_W   = 7;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_SEARCH = 3'd1,
    CMD_PRE    = 3'd2,
    CMD_IN     = 3'd3,
    CMD_POST   = 3'd4,
    CMD_LEAF   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_FOUND     = 3'd3,
    STS_EMPTY     = 3'd4
  } status_t;

  // Index step applied to the heap cursor (1-based slot number).
  typedef enum logic [2:0] {
    K_HOLD,
    K_ROOT,
    K_LEFT,
    K_RIGHT,
    K_UP,
    K_NEXT
  } kop_t;

  // What goes into the pending result register.
  typedef enum logic [2:0] {
    RES_FULL,
    RES_OK,
    RES_NOT_FOUND,
    RES_FOUND,
    RES_EMPTY,
    RES_LEAF,
    RES_NODE
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RESP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DESC,
    S_RD,
    S_VISIT,
    S_ADV,
    S_UP
  } state_t;

  typedef struct packed {
    logic capture;
    kop_t kop;
    logic wr_en;
    logic res_set;
    res_t res_sel;
    logic out_ld;
    logic out_last;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             has_left;
    logic             has_right;
    logic             sib_ok;
    logic             k_odd;
    logic             k_root;
    logic             k_end;
    logic             match;
    logic             pend_full;
    logic             out_free;
  } stat_t;

endpackage

// File: rtl/complete_binary_tree_engine_unit.sv
// Top level of the complete binary tree engine: controller plus datapath.
//
//  channel | ports                                              | dir | handshake
//  --------+----------------------------------------------------+-----+----------------------
//  input   | in_cmd[2:0], in_value[31:0]                        | in  | in_valid / in_ready
//  result  | out_status[2:0], out_item_value[31:0],             | out | out_valid / out_ready
//          | out_leaf_total[6:0], out_last                      |     |
//
//  One item is worked at a time; in_ready is high only while the controller is idle.
//  Insert and leaf count: captured in idle, result set in decode, loaded in the response state.
//  Search: each stored slot is read from the registered RAM and then compared, in slot order,
//  until a match or the last slot. Walks: the cursor steps one heap link at a time, and
//  each node is read from the registered node store before it is visited.
//  Reset clears the node count and all control state; the store is never swept.
//  A stalled result (out_ready low) holds the walk at the next node visit.
module complete_binary_tree_engine_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cbt_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [cbt_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cbt_pkg::STAT_W-1:0]        out_status,
  output logic signed [cbt_pkg::DATA_W-1:0] out_item_value,
  output logic [cbt_pkg::LEAF_W-1:0]        out_leaf_total,
  output logic                              out_last
);

  // Command and status links between controller and datapath.
  cbt_pkg::ctl_t  ctl;
  cbt_pkg::stat_t stat;

  // Datapath: node store RAM, node count, heap cursor, pending and output registers.
  cbt_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .ctl           (ctl),
    .stat          (stat),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_item_value(out_item_value),
    .out_leaf_total(out_leaf_total),
    .out_last      (out_last)
  );

  // Controller: decode the item, scan for a key, or step the cursor through a walk
  // without a stack, using only parent/child/sibling index moves.
  cbt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .ctl     (ctl)
  );

endmodule

// File: rtl/cbt_ram.sv
// Generic simple dual-port RAM with registered read.
module cbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/cbt_datapath.sv
// Datapath: node store, node count, heap cursor, pending result and output register.
module cbt_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cbt_pkg::CMD_W-1:0]    in_cmd,
  input  logic signed [cbt_pkg::DATA_W-1:0] in_value,
  input  cbt_pkg::ctl_t                ctl,
  output cbt_pkg::stat_t               stat,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [cbt_pkg::STAT_W-1:0]   out_status,
  output logic signed [cbt_pkg::DATA_W-1:0] out_item_value,
  output logic [cbt_pkg::LEAF_W-1:0]   out_leaf_total,
  output logic                         out_last
);

  localparam int NW = cbt_pkg::NODE_W;

  logic [cbt_pkg::CMD_W-1:0]  cmd_r;
  logic [cbt_pkg::DATA_W-1:0] key_r;
  logic [NW-1:0]              n_r, n_nxt;
  logic [NW-1:0]              k_r, k_nxt;
  logic [cbt_pkg::DATA_W-1:0] rd_data;

  logic                       pend_full_r, pend_full_nxt;
  logic [cbt_pkg::STAT_W-1:0] pend_status_r, pend_status_nxt;
  logic [cbt_pkg::DATA_W-1:0] pend_value_r, pend_value_nxt;
  logic [cbt_pkg::LEAF_W-1:0] pend_leaf_r, pend_leaf_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [cbt_pkg::STAT_W-1:0] out_status_r;
  logic [cbt_pkg::DATA_W-1:0] out_value_r;
  logic [cbt_pkg::LEAF_W-1:0] out_leaf_r;
  logic                       out_last_r;

  logic [NW:0] k2, n_ext, k_inc;
  logic [NW-1:0] leaves;

  cbt_ram #(
    .WIDTH(cbt_pkg::DATA_W),
    .DEPTH(cbt_pkg::CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (ctl.wr_en),
    .wr_addr(n_r[cbt_pkg::ADDR_W-1:0]),
    .wr_data(key_r),
    .rd_addr(cbt_pkg::ADDR_W'(k_r - 1'b1)),
    .rd_data(rd_data)
  );

  assign k2     = {k_r, 1'b0};
  assign n_ext  = {1'b0, n_r};
  assign k_inc  = {1'b0, k_r} + 1'b1;
  assign leaves = n_r - (n_r >> 1);

  always_comb begin
    stat.cmd       = cmd_r;
    stat.full      = (n_ext >= (NW+1)'(cbt_pkg::CAPACITY));
    stat.empty     = (n_r == '0);
    stat.has_left  = (k2 <= n_ext);
    stat.has_right = ((k2 | (NW+1)'(1)) <= n_ext);
    stat.sib_ok    = (k_inc <= n_ext);
    stat.k_odd     = k_r[0];
    stat.k_root    = (k_r == NW'(1));
    stat.k_end     = (k_r == n_r);
    stat.match     = (rd_data == key_r);
    stat.pend_full = pend_full_r;
    stat.out_free  = !out_valid_r || out_ready;
  end

  // Cursor and node count.
  always_comb begin
    k_nxt = k_r;
    case (ctl.kop)
      cbt_pkg::K_HOLD:  k_nxt = k_r;
      cbt_pkg::K_ROOT:  k_nxt = NW'(1);
      cbt_pkg::K_LEFT:  k_nxt = k2[NW-1:0];
      cbt_pkg::K_RIGHT: k_nxt = k2[NW-1:0] | NW'(1);
      cbt_pkg::K_UP:    k_nxt = k_r >> 1;
      cbt_pkg::K_NEXT:  k_nxt = k_inc[NW-1:0];
      default:          k_nxt = k_r;
    endcase
    n_nxt = ctl.wr_en ? n_r + 1'b1 : n_r;
  end

  // Pending result: filled by the controller, drained into the output register.
  always_comb begin
    pend_status_nxt = pend_status_r;
    pend_value_nxt  = pend_value_r;
    pend_leaf_nxt   = pend_leaf_r;
    pend_full_nxt   = pend_full_r;
    if (ctl.out_ld) begin
      pend_full_nxt = 1'b0;
    end
    if (ctl.res_set) begin
      pend_full_nxt   = 1'b1;
      pend_value_nxt  = '0;
      pend_leaf_nxt   = '0;
      pend_status_nxt = cbt_pkg::STS_OK;
      case (ctl.res_sel)
        cbt_pkg::RES_FULL:      pend_status_nxt = cbt_pkg::STS_FULL;
        cbt_pkg::RES_OK:        pend_status_nxt = cbt_pkg::STS_OK;
        cbt_pkg::RES_NOT_FOUND: pend_status_nxt = cbt_pkg::STS_NOT_FOUND;
        cbt_pkg::RES_FOUND: begin
          pend_status_nxt = cbt_pkg::STS_FOUND;
          pend_value_nxt  = key_r;
        end
        cbt_pkg::RES_EMPTY:     pend_status_nxt = cbt_pkg::STS_EMPTY;
        cbt_pkg::RES_LEAF:      pend_leaf_nxt   = cbt_pkg::LEAF_W'(leaves);
        cbt_pkg::RES_NODE:      pend_value_nxt  = rd_data;
        default:                pend_status_nxt = cbt_pkg::STS_OK;
      endcase
    end
  end

  always_comb begin
    if (ctl.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      pend_full_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      pend_full_r <= pend_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_cmd;
      key_r <= in_value;
    end
    k_r           <= k_nxt;
    pend_status_r <= pend_status_nxt;
    pend_value_r  <= pend_value_nxt;
    pend_leaf_r   <= pend_leaf_nxt;
    if (ctl.out_ld) begin
      out_status_r <= pend_status_r;
      out_value_r  <= pend_value_r;
      out_leaf_r   <= pend_leaf_r;
      out_last_r   <= ctl.out_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_item_value = out_value_r;
  assign out_leaf_total = out_leaf_r;
  assign out_last       = out_last_r;

endmodule

// File: rtl/cbt_ctrl.sv
// Controller state machine: command decode, search scan and stackless tree walks.
module cbt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cbt_pkg::stat_t stat,
  output cbt_pkg::ctl_t  ctl
);

  cbt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = cbt_pkg::S_DECODE;
      end
      cbt_pkg::S_DECODE: begin
        case (stat.cmd)
          cbt_pkg::CMD_INSERT: state_nxt = cbt_pkg::S_RESP;
          cbt_pkg::CMD_SEARCH:
            state_nxt = stat.empty ? cbt_pkg::S_RESP : cbt_pkg::S_SRCH_RD;
          cbt_pkg::CMD_PRE:
            state_nxt = stat.empty ? cbt_pkg::S_RESP : cbt_pkg::S_RD;
          cbt_pkg::CMD_IN, cbt_pkg::CMD_POST:
            state_nxt = stat.empty ? cbt_pkg::S_RESP : cbt_pkg::S_DESC;
          cbt_pkg::CMD_LEAF:   state_nxt = cbt_pkg::S_RESP;
          default:             state_nxt = cbt_pkg::S_IDLE;
        endcase
      end
      cbt_pkg::S_RESP: begin
        if (stat.out_free) state_nxt = cbt_pkg::S_IDLE;
      end
      cbt_pkg::S_SRCH_RD: state_nxt = cbt_pkg::S_SRCH_CMP;
      cbt_pkg::S_SRCH_CMP: begin
        if (stat.match || stat.k_end) begin
          state_nxt = cbt_pkg::S_RESP;
        end else begin
          state_nxt = cbt_pkg::S_SRCH_RD;
        end
      end
      cbt_pkg::S_DESC: begin
        if (!stat.has_left) state_nxt = cbt_pkg::S_RD;
      end
      cbt_pkg::S_RD: state_nxt = cbt_pkg::S_VISIT;
      cbt_pkg::S_VISIT: begin
        if (!stat.pend_full || stat.out_free) state_nxt = cbt_pkg::S_ADV;
      end
      cbt_pkg::S_ADV: begin
        case (stat.cmd)
          cbt_pkg::CMD_PRE:
            state_nxt = stat.has_left ? cbt_pkg::S_RD : cbt_pkg::S_UP;
          cbt_pkg::CMD_IN:
            state_nxt = stat.has_right ? cbt_pkg::S_DESC : cbt_pkg::S_UP;
          cbt_pkg::CMD_POST: begin
            if (stat.k_root) begin
              state_nxt = cbt_pkg::S_RESP;
            end else if (!stat.k_odd && stat.sib_ok) begin
              state_nxt = cbt_pkg::S_DESC;
            end else begin
              state_nxt = cbt_pkg::S_RD;
            end
          end
          default: state_nxt = cbt_pkg::S_RESP;
        endcase
      end
      cbt_pkg::S_UP: begin
        case (stat.cmd)
          cbt_pkg::CMD_PRE: begin
            if (stat.k_root) begin
              state_nxt = cbt_pkg::S_RESP;
            end else if (!stat.k_odd && stat.sib_ok) begin
              state_nxt = cbt_pkg::S_RD;
            end
          end
          cbt_pkg::CMD_IN: begin
            if (stat.k_root) begin
              state_nxt = cbt_pkg::S_RESP;
            end else if (!stat.k_odd) begin
              state_nxt = cbt_pkg::S_RD;
            end
          end
          default: state_nxt = cbt_pkg::S_RESP;
        endcase
      end
      default: state_nxt = cbt_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl          = '0;
    ctl.kop      = cbt_pkg::K_HOLD;
    ctl.res_sel  = cbt_pkg::RES_OK;
    in_ready     = 1'b0;
    case (state_r)
      cbt_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      cbt_pkg::S_DECODE: begin
        case (stat.cmd)
          cbt_pkg::CMD_INSERT: begin
            ctl.wr_en   = !stat.full;
            ctl.res_set = 1'b1;
            ctl.res_sel = stat.full ? cbt_pkg::RES_FULL : cbt_pkg::RES_OK;
          end
          cbt_pkg::CMD_SEARCH: begin
            ctl.kop     = cbt_pkg::K_ROOT;
            ctl.res_set = stat.empty;
            ctl.res_sel = cbt_pkg::RES_NOT_FOUND;
          end
          cbt_pkg::CMD_PRE, cbt_pkg::CMD_IN, cbt_pkg::CMD_POST: begin
            ctl.kop     = cbt_pkg::K_ROOT;
            ctl.res_set = stat.empty;
            ctl.res_sel = cbt_pkg::RES_EMPTY;
          end
          cbt_pkg::CMD_LEAF: begin
            ctl.res_set = 1'b1;
            ctl.res_sel = cbt_pkg::RES_LEAF;
          end
          default: ctl.res_set = 1'b0;
        endcase
      end
      cbt_pkg::S_RESP: begin
        ctl.out_ld   = stat.out_free;
        ctl.out_last = 1'b1;
      end
      cbt_pkg::S_SRCH_CMP: begin
        if (stat.match) begin
          ctl.res_set = 1'b1;
          ctl.res_sel = cbt_pkg::RES_FOUND;
        end else if (stat.k_end) begin
          ctl.res_set = 1'b1;
          ctl.res_sel = cbt_pkg::RES_NOT_FOUND;
        end else begin
          ctl.kop = cbt_pkg::K_NEXT;
        end
      end
      cbt_pkg::S_DESC: begin
        if (stat.has_left) ctl.kop = cbt_pkg::K_LEFT;
      end
      cbt_pkg::S_VISIT: begin
        // Emit the previous node only once its successor is known.
        ctl.res_sel = cbt_pkg::RES_NODE;
        if (!stat.pend_full) begin
          ctl.res_set = 1'b1;
        end else if (stat.out_free) begin
          ctl.res_set = 1'b1;
          ctl.out_ld  = 1'b1;
        end
      end
      cbt_pkg::S_ADV: begin
        case (stat.cmd)
          cbt_pkg::CMD_PRE: begin
            if (stat.has_left) ctl.kop = cbt_pkg::K_LEFT;
          end
          cbt_pkg::CMD_IN: begin
            if (stat.has_right) ctl.kop = cbt_pkg::K_RIGHT;
          end
          cbt_pkg::CMD_POST: begin
            if (!stat.k_root) begin
              ctl.kop = (!stat.k_odd && stat.sib_ok) ? cbt_pkg::K_NEXT : cbt_pkg::K_UP;
            end
          end
          default: ctl.kop = cbt_pkg::K_HOLD;
        endcase
      end
      cbt_pkg::S_UP: begin
        case (stat.cmd)
          cbt_pkg::CMD_PRE: begin
            if (!stat.k_root) begin
              ctl.kop = (!stat.k_odd && stat.sib_ok) ? cbt_pkg::K_NEXT : cbt_pkg::K_UP;
            end
          end
          cbt_pkg::CMD_IN: begin
            if (!stat.k_root) ctl.kop = cbt_pkg::K_UP;
          end
          default: ctl.kop = cbt_pkg::K_HOLD;
        endcase
      end
      default: ctl.kop = cbt_pkg::K_HOLD;
    endcase
  end

endmodule
